>>> hdl/swce_pkg.sv
// ----------------------------------------------------------------------------
// swce_pkg
// Shared types and constants of the sparse weight change encoder.
// ----------------------------------------------------------------------------
package swce_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int CH_W         = 6;
    localparam int CFG_W        = 7;
    localparam int WEIGHT_W     = 16;
    localparam int BYTE_W       = 8;
    localparam int FRAME_W      = 16;
    localparam int PAIR_CNT_W   = 9;

    localparam logic [CFG_W-1:0]      CHANNEL_COUNT_RESET = CFG_W'(MAX_CHANNELS);
    localparam logic [PAIR_CNT_W-1:0] PAIR_SAT            = PAIR_CNT_W'(256);

    // quantiser: round(w * 255) on a q4.12 weight
    localparam int QUANT_SCALE = 255;
    localparam int QUANT_HALF  = 2048;
    localparam int PROD_W      = 25;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input action codes
    localparam logic [1:0] ACT_SAMPLE    = 2'd0;
    localparam logic [1:0] ACT_FRAME_END = 2'd1;
    localparam logic [1:0] ACT_START     = 2'd2;

    // result kinds
    localparam logic RESULT_PAIR  = 1'b0;
    localparam logic RESULT_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_FRAME_END,
        OP_START
    } op_kind_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [CH_W-1:0]       ch;
        logic [BYTE_W-1:0]     value;
    } queue_entry_t;

endpackage

>>> hdl/swce_front.sv
// ----------------------------------------------------------------------------
// swce_front
// Accepts input transactions, quantises the weight and classifies the item
// into a queue operation; ignored items are accepted and dropped here.
// ----------------------------------------------------------------------------
module swce_front (
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              action,
    input  logic [swce_pkg::CH_W-1:0]               channel_index,
    input  logic signed [swce_pkg::WEIGHT_W-1:0]    weight_value,
    input  logic [swce_pkg::CFG_W-1:0]              channel_count,
    input  logic                                    q_full,
    output logic                                    q_push,
    output swce_pkg::queue_entry_t                  q_entry
);
    import swce_pkg::*;

    logic signed [PROD_W-1:0] rounded;
    logic [BYTE_W-1:0]        quant;
    logic                     ch_in_range;
    logic                     keep;

    always_comb
    begin
        rounded = PROD_W'(weight_value) * PROD_W'(QUANT_SCALE) + PROD_W'(QUANT_HALF);
        if (rounded[PROD_W-1])
        begin
            quant = '0;
        end
        else if (|rounded[PROD_W-2:12+BYTE_W])
        begin
            quant = '1;
        end
        else
        begin
            quant = rounded[12+BYTE_W-1:12];
        end
    end

    assign ch_in_range = ({1'b0, channel_index} < channel_count)
                      && ({1'b0, channel_index} < CFG_W'(MAX_CHANNELS));

    always_comb
    begin
        keep          = 1'b0;
        q_entry.kind  = OP_SAMPLE;
        q_entry.ch    = channel_index;
        q_entry.value = quant;
        case (action)
            ACT_SAMPLE:
            begin
                keep = ch_in_range;
            end
            ACT_FRAME_END:
            begin
                keep         = 1'b1;
                q_entry.kind = OP_FRAME_END;
            end
            ACT_START:
            begin
                keep         = 1'b1;
                q_entry.kind = OP_START;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && keep;

endmodule

>>> hdl/swce_queue.sv
// ----------------------------------------------------------------------------
// swce_queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module swce_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  swce_pkg::queue_entry_t  push_entry,
    input  logic                    pop,
    output swce_pkg::queue_entry_t  head,
    output logic                    empty,
    output logic                    full
);
    import swce_pkg::*;

    queue_entry_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg;
    logic [QPTR_W-1:0]      rd_ptr_reg;
    logic [QCNT_W-1:0]      count_reg;
    logic [QCNT_W-1:0]      count_next;

    assign head  = entries_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hdl/swce_back.sv
// ----------------------------------------------------------------------------
// swce_back
// Executes queued operations against the per-channel history memory and
// the frame counters, and holds the output register.
// ----------------------------------------------------------------------------
module swce_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  swce_pkg::queue_entry_t          q_head,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            result_kind,
    output logic [swce_pkg::CH_W-1:0]       pair_index,
    output logic [swce_pkg::BYTE_W-1:0]     pair_value,
    output logic [swce_pkg::BYTE_W-1:0]     frame_pairs,
    output logic [swce_pkg::FRAME_W-1:0]    frame_number,
    output logic                            count_overflow
);
    import swce_pkg::*;

    // history word: older byte above, newer byte below
    logic [2*BYTE_W-1:0]        hist_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]    hist_valid_reg;
    logic [2*BYTE_W-1:0]        rd_word_reg;

    logic                       s2_valid_reg;
    queue_entry_t               s2_op_reg;

    // write made at the edge the current operation read the memory
    logic                       fwd_valid_reg;
    logic [CH_W-1:0]            fwd_ch_reg;
    logic [2*BYTE_W-1:0]        fwd_word_reg;

    logic [PAIR_CNT_W-1:0]      pair_counter_reg;
    logic [FRAME_W-1:0]         frame_counter_reg;

    logic                       out_valid_reg;
    logic                       result_kind_reg;
    logic [CH_W-1:0]            pair_index_reg;
    logic [BYTE_W-1:0]          pair_value_reg;
    logic [BYTE_W-1:0]          frame_pairs_reg;
    logic [FRAME_W-1:0]         frame_number_reg;
    logic                       count_overflow_reg;

    logic [2*BYTE_W-1:0]        hist_word;
    logic [BYTE_W-1:0]          older;
    logic [BYTE_W-1:0]          newer;
    logic                       is_sample;
    logic                       is_frame_end;
    logic                       is_start;
    logic                       changed;
    logic                       emits;
    logic                       out_free;
    logic                       s2_fire;
    logic                       wr_en;
    logic [2*BYTE_W-1:0]        wr_word;
    logic [PAIR_CNT_W-1:0]      pair_counter_next;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_ch_reg == s2_op_reg.ch))
        begin
            hist_word = fwd_word_reg;
        end
        else if (hist_valid_reg[s2_op_reg.ch])
        begin
            hist_word = rd_word_reg;
        end
        else
        begin
            hist_word = '0;
        end
    end

    assign older        = hist_word[2*BYTE_W-1:BYTE_W];
    assign newer        = hist_word[BYTE_W-1:0];
    assign is_sample    = (s2_op_reg.kind == OP_SAMPLE);
    assign is_frame_end = (s2_op_reg.kind == OP_FRAME_END);
    assign is_start     = (s2_op_reg.kind == OP_START);
    assign changed      = !((older == s2_op_reg.value) && (newer == s2_op_reg.value));
    assign emits        = (is_sample && changed) || is_frame_end;
    assign out_free     = !out_valid_reg || !out_stall;
    assign s2_fire      = s2_valid_reg && (!emits || out_free);
    assign wr_en        = s2_fire && is_sample && changed;
    assign wr_word      = {newer, s2_op_reg.value};
    assign q_pop        = !q_empty && (!s2_valid_reg || s2_fire);

    always_comb
    begin
        pair_counter_next = pair_counter_reg;
        if (pair_counter_reg < PAIR_SAT)
        begin
            pair_counter_next = pair_counter_reg + 1'b1;
        end
    end

    // history memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[s2_op_reg.ch] <= wr_word;
        end
        if (q_pop)
        begin
            rd_word_reg <= hist_mem[q_head.ch];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_op_reg    <= q_head;
            fwd_ch_reg   <= s2_op_reg.ch;
            fwd_word_reg <= wr_word;
        end
        if (s2_fire && emits)
        begin
            result_kind_reg    <= is_frame_end ? RESULT_COUNT : RESULT_PAIR;
            pair_index_reg     <= is_frame_end ? '0 : s2_op_reg.ch;
            pair_value_reg     <= is_frame_end ? '0 : s2_op_reg.value;
            frame_pairs_reg    <= !is_frame_end ? '0
                                : (pair_counter_reg[PAIR_CNT_W-1] ? '1
                                   : pair_counter_reg[BYTE_W-1:0]);
            frame_number_reg   <= is_frame_end ? frame_counter_reg : '0;
            count_overflow_reg <= is_frame_end && (pair_counter_reg >= PAIR_SAT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg      <= 1'b0;
            fwd_valid_reg     <= 1'b0;
            hist_valid_reg    <= '0;
            pair_counter_reg  <= '0;
            frame_counter_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                s2_valid_reg  <= 1'b1;
                fwd_valid_reg <= wr_en;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_fire && emits)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s2_fire)
            begin
                if (is_start)
                begin
                    hist_valid_reg    <= '0;
                    pair_counter_reg  <= '0;
                    frame_counter_reg <= '0;
                end
                else if (is_frame_end)
                begin
                    pair_counter_reg  <= '0;
                    frame_counter_reg <= frame_counter_reg + 1'b1;
                end
                else if (changed)
                begin
                    hist_valid_reg[s2_op_reg.ch] <= 1'b1;
                    pair_counter_reg             <= pair_counter_next;
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = result_kind_reg;
    assign pair_index     = pair_index_reg;
    assign pair_value     = pair_value_reg;
    assign frame_pairs    = frame_pairs_reg;
    assign frame_number   = frame_number_reg;
    assign count_overflow = count_overflow_reg;

    a_pair_counter_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        pair_counter_reg <= PAIR_SAT
    ) else $error("pair counter beyond saturation");

    a_overflow_saturates: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && (result_kind_reg == RESULT_COUNT) && count_overflow_reg
            |-> (frame_pairs_reg == '1)
    ) else $error("overflow reported without saturated count");

    a_pair_fields_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && (result_kind_reg == RESULT_PAIR)
            |-> (frame_pairs_reg == '0) && (frame_number_reg == '0) && !count_overflow_reg
    ) else $error("pair result carries frame fields");

    a_start_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        s2_fire && is_start
            |=> (hist_valid_reg == '0) && (pair_counter_reg == '0)
                && (frame_counter_reg == '0)
    ) else $error("start did not clear history and counters");

endmodule

>>> hdl/sparse_weight_change_encoder_top.sv
// ----------------------------------------------------------------------------
// sparse_weight_change_encoder_top
// Quantises channel weights and emits changed (index, value) pairs and a
// per-frame pair count.
// ----------------------------------------------------------------------------
// path: queue entry, back-part operation register, then the output register
// throughput: one transaction per cycle unless stalled, set by the history
//   read-modify-write in the back part with write forwarding
// reset: history, counters and queue are cleared at once; channel_count
//   returns to 64; the block accepts input as soon as reset is released
module sparse_weight_change_encoder_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [swce_pkg::CFG_W-1:0]              cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              action,
    input  logic [swce_pkg::CH_W-1:0]               channel_index,
    input  logic signed [swce_pkg::WEIGHT_W-1:0]    weight_value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    result_kind,
    output logic [swce_pkg::CH_W-1:0]               pair_index,
    output logic [swce_pkg::BYTE_W-1:0]             pair_value,
    output logic [swce_pkg::BYTE_W-1:0]             frame_pairs,
    output logic [swce_pkg::FRAME_W-1:0]            frame_number,
    output logic                                    count_overflow
);
    import swce_pkg::*;

    logic [CFG_W-1:0]   channel_count_reg;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    queue_entry_t       q_entry;
    queue_entry_t       q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CHANNEL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            channel_count_reg <= cfg_wdata;
        end
    end

    swce_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .channel_index (channel_index),
        .weight_value  (weight_value),
        .channel_count (channel_count_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    swce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    swce_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .pair_index     (pair_index),
        .pair_value     (pair_value),
        .frame_pairs    (frame_pairs),
        .frame_number   (frame_number),
        .count_overflow (count_overflow)
    );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sparse weight change encoder. A queue of
// weight samples, frame ends and starts is driven through the input channel
// in random bursts. An in-bench encoder predicts every pair and frame-count
// result, and the monitor checks each one against the oldest prediction while
// the output side stalls on its own pattern. The channel count register is
// stepped through its extremes between phases. Long frames push the pair
// count up to and beyond saturation.
// ----------------------------------------------------------------------------
module tb;

    import swce_pkg::*;

    localparam logic [1:0] ACT_UNDEFINED = 2'd3;
    localparam int FRAC_BITS    = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLDOFF_LEN  = 120;
    localparam int REPORT_CAP   = 100;

    typedef struct packed {
        logic [1:0]                 act;
        logic [CH_W-1:0]            ch;
        logic signed [WEIGHT_W-1:0] w;
    } weight_item_t;

    typedef struct packed {
        logic                kind;
        logic [CH_W-1:0]     idx;
        logic [BYTE_W-1:0]   value;
        logic [BYTE_W-1:0]   pairs;
        logic [FRAME_W-1:0]  frame;
        logic                overflow;
    } enc_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_W-1:0]           cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [1:0]                 action = ACT_SAMPLE;
    logic [CH_W-1:0]            channel_index = '0;
    logic signed [WEIGHT_W-1:0] weight_value = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       result_kind;
    logic [CH_W-1:0]            pair_index;
    logic [BYTE_W-1:0]          pair_value;
    logic [BYTE_W-1:0]          frame_pairs;
    logic [FRAME_W-1:0]         frame_number;
    logic                       count_overflow;

    // stimulus and predictions
    weight_item_t pending_items[$];
    enc_result_t  results_due[$];
    int           mismatch_count = 0;

    // predicted encoder state
    logic [BYTE_W-1:0]     hist_older[MAX_CHANNELS];
    logic [BYTE_W-1:0]     hist_newer[MAX_CHANNELS];
    logic [PAIR_CNT_W-1:0] pairs_in_frame;
    logic [FRAME_W-1:0]    frames_done;
    logic [CFG_W-1:0]      chan_limit;

    // sender and receiver pacing
    int   burst_left = 0;
    int   gap_left = 0;
    int   seg_left = 0;
    int   stall_mode = 0;
    int   stall_tick = 0;
    int   holdoff_left = 0;
    logic holdoff_req = 1'b0;
    logic holdoff_seen = 1'b0;

    sparse_weight_change_encoder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .channel_index  (channel_index),
        .weight_value   (weight_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .pair_index     (pair_index),
        .pair_value     (pair_value),
        .frame_pairs    (frame_pairs),
        .frame_number   (frame_number),
        .count_overflow (count_overflow)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // round(w * 255) on a q4.12 weight, clamped to a byte
    function automatic logic [BYTE_W-1:0] to_byte(input logic signed [WEIGHT_W-1:0] w);
        int t;
        t = int'(w) * QUANT_SCALE + QUANT_HALF;
        if (t < 0)
            return '0;
        t = t >>> FRAC_BITS;
        if (t > 255)
            return 8'd255;
        return t[BYTE_W-1:0];
    endfunction

    function automatic void clear_history();
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            hist_older[c] = '0;
            hist_newer[c] = '0;
        end
        pairs_in_frame = '0;
        frames_done    = '0;
    endfunction

    function automatic void encode_item(input logic [1:0] act, input logic [CH_W-1:0] ch,
                                        input logic signed [WEIGHT_W-1:0] w);
        enc_result_t       r;
        logic [BYTE_W-1:0] b;
        r = '0;
        case (act)
            ACT_SAMPLE:
            begin
                if (ch < chan_limit && int'(ch) < MAX_CHANNELS)
                begin
                    b = to_byte(w);
                    if (!(hist_older[ch] == b && hist_newer[ch] == b))
                    begin
                        hist_older[ch] = hist_newer[ch];
                        hist_newer[ch] = b;
                        if (pairs_in_frame < PAIR_SAT)
                            pairs_in_frame++;
                        r.kind  = RESULT_PAIR;
                        r.idx   = ch;
                        r.value = b;
                        results_due = {results_due, r};
                    end
                end
            end
            ACT_FRAME_END:
            begin
                r.kind     = RESULT_COUNT;
                r.pairs    = (pairs_in_frame > 255) ? 8'd255 : pairs_in_frame[BYTE_W-1:0];
                r.frame    = frames_done;
                r.overflow = (pairs_in_frame >= PAIR_SAT);
                results_due = {results_due, r};
                frames_done++;
                pairs_in_frame = '0;
            end
            ACT_START:
                clear_history();
            default: ;
        endcase
    endfunction

    // driver: one transaction per accepted edge, bursts separated by gaps
    always @(posedge clk or negedge rst_n)
    begin
        weight_item_t nxt;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            action        <= ACT_SAMPLE;
            channel_index <= '0;
            weight_value  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                encode_item(action, channel_index, weight_value);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 || pending_items.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    nxt = pending_items.pop_front();
                    in_valid      <= 1'b1;
                    action        <= nxt.act;
                    channel_index <= nxt.ch;
                    weight_value  <= nxt.w;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver stall pattern, with an occasional long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (holdoff_req != holdoff_seen)
            begin
                holdoff_seen = holdoff_req;
                holdoff_left = HOLDOFF_LEN;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left   = $urandom_range(1, 64);
                    stall_mode = $urandom_range(0, 3);
                end
                seg_left--;
                stall_tick = (stall_tick + 1) % 3;
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (stall_tick == 0);
                endcase
            end
        end
    end

    // monitor: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        enc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
                report_mismatch("result with nothing due, result_kind", int'(result_kind), 0);
            else
            begin
                want = results_due.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch("result_kind", int'(result_kind), int'(want.kind));
                if (pair_index !== want.idx)
                    report_mismatch("pair_index", int'(pair_index), int'(want.idx));
                if (pair_value !== want.value)
                    report_mismatch("pair_value", int'(pair_value), int'(want.value));
                if (frame_pairs !== want.pairs)
                    report_mismatch("frame_pairs", int'(frame_pairs), int'(want.pairs));
                if (frame_number !== want.frame)
                    report_mismatch("frame_number", int'(frame_number), int'(want.frame));
                if (count_overflow !== want.overflow)
                    report_mismatch("count_overflow", int'(count_overflow),
                                    int'(want.overflow));
            end
        end
    end

    function automatic void queue_item(input logic [1:0] act, input logic [CH_W-1:0] ch,
                                       input logic signed [WEIGHT_W-1:0] w);
        weight_item_t it;
        it.act = act;
        it.ch  = ch;
        it.w   = w;
        pending_items = {pending_items, it};
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] pick_weight();
        logic signed [WEIGHT_W-1:0] few[6];
        int r;
        few = '{16'sd0, 16'sd4096, 16'sd2048, 16'sd1024, 16'sd3000, -16'sd5};
        r = $urandom_range(0, 99);
        if (r < 40)
            return few[$urandom_range(0, 5)];
        else if (r < 70)
            return WEIGHT_W'($urandom_range(0, 4096));
        return WEIGHT_W'($urandom());
    endfunction

    // mostly well-formed frames of samples, with starts and some noise
    function automatic void queue_random_traffic(input int n_items);
        int lim;
        int r;
        logic [CH_W-1:0] ch;
        lim = (chan_limit > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_limit);
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                queue_item(ACT_START, CH_W'($urandom()), WEIGHT_W'($urandom()));
            else if (r < 6)
                queue_item(ACT_UNDEFINED, CH_W'($urandom()), WEIGHT_W'($urandom()));
            else if (r < 13)
                queue_item(ACT_FRAME_END, CH_W'($urandom()), WEIGHT_W'($urandom()));
            else
            begin
                if (lim == 0 || $urandom_range(0, 99) < 15)
                    ch = CH_W'($urandom());
                else if ($urandom_range(0, 1) == 0)
                    ch = CH_W'($urandom_range(0, (lim < 4) ? lim - 1 : 3));
                else
                    ch = CH_W'($urandom_range(0, lim - 1));
                queue_item(ACT_SAMPLE, ch, pick_weight());
            end
        end
        queue_item(ACT_FRAME_END, '0, '0);
    endfunction

    // every sample changes the byte, so the frame holds exactly n_pairs pairs
    function automatic void queue_busy_frame(input int n_pairs, input logic [CH_W-1:0] ch);
        logic signed [WEIGHT_W-1:0] cyc[3];
        cyc = '{16'sd4096, 16'sd2048, 16'sd0};
        for (int i = 0; i < n_pairs; i++)
            queue_item(ACT_SAMPLE, ch, cyc[i % 3]);
        queue_item(ACT_FRAME_END, ch, '0);
    endfunction

    task automatic wait_until_quiet();
        while (pending_items.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        // samples that emit nothing may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_channel_count(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        chan_limit = v;
    endtask

    initial
    begin
        logic [CFG_W-1:0] settings[9];
        int n;
        clear_history();
        chan_limit = CHANNEL_COUNT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: rounding, clamping, history equality, undefined action
        queue_item(ACT_START, '0, '0);
        queue_item(ACT_SAMPLE, 6'd0, 16'sd0);
        queue_item(ACT_SAMPLE, 6'd0, 16'sd4096);
        queue_item(ACT_SAMPLE, 6'd0, 16'sd4096);
        queue_item(ACT_SAMPLE, 6'd0, 16'sd4096);
        queue_item(ACT_SAMPLE, 6'd63, -16'sd32768);
        queue_item(ACT_SAMPLE, 6'd63, 16'sd32767);
        queue_item(ACT_SAMPLE, 6'd63, -16'sd1);
        queue_item(ACT_SAMPLE, 6'd1, 16'sd2048);
        queue_item(ACT_SAMPLE, 6'd2, 16'sd9);
        queue_item(ACT_SAMPLE, 6'd2, 16'sd8);
        queue_item(ACT_UNDEFINED, 6'd5, 16'sd4096);
        queue_item(ACT_FRAME_END, '0, '0);
        queue_item(ACT_FRAME_END, 6'h3f, -16'sd1);
        queue_item(ACT_START, 6'h3f, -16'sd1);
        queue_item(ACT_FRAME_END, '0, '0);
        wait_until_quiet();

        // single channel in use
        write_channel_count(7'd1);
        queue_item(ACT_SAMPLE, 6'd0, 16'sd4096);
        queue_item(ACT_SAMPLE, 6'd1, 16'sd4096);
        queue_item(ACT_FRAME_END, '0, '0);
        wait_until_quiet();

        // no channel in use: every sample ignored
        write_channel_count(7'd0);
        queue_item(ACT_SAMPLE, 6'd0, 16'sd2048);
        queue_item(ACT_FRAME_END, '0, '0);
        wait_until_quiet();

        // count above the array acts as the full channel set
        write_channel_count(7'd127);
        queue_item(ACT_SAMPLE, 6'd63, 16'sd1024);
        queue_item(ACT_FRAME_END, '0, '0);
        wait_until_quiet();

        // pair count beyond and just below saturation; output held off
        write_channel_count(7'd64);
        queue_item(ACT_START, '0, '0);
        queue_busy_frame(257, 6'd7);
        @(posedge clk);
        holdoff_req <= ~holdoff_req;
        queue_busy_frame(255, 6'd5);
        wait_until_quiet();

        settings = '{7'd64, 7'd1, 7'd2, 7'd7, 7'd33, 7'd0, 7'd127, 7'd100,
                     CFG_W'($urandom_range(1, 64))};
        for (int p = 0; p < 9; p++)
        begin
            write_channel_count(settings[p]);
            queue_random_traffic(50);
            wait_until_quiet();
        end

        write_channel_count(CFG_W'($urandom_range(1, 64)));
        queue_random_traffic(40);

        for (n = 0; n < 20000 && (pending_items.size() != 0 || in_valid ||
                                  results_due.size() != 0); n++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch("results never produced", 0, results_due.size());

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
